// ===== rtl/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

    localparam int MAX_DIVISIONS     = 256;
    localparam int ANGLE_BITS        = 16;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int COUNT_W = 9;
    localparam int NUM_W   = COUNT_W + ANGLE_BITS;
    localparam int NUM_CW  = $clog2(NUM_W + 1);
    localparam int ITER_W  = $clog2(CORDIC_ITERATIONS);
    localparam int IDX_W   = 17;
    localparam int POS_W   = 17;
    localparam int XY_W    = 33;
    localparam int PROD_W  = POS_W + XY_W;
    localparam int RAD_W   = 16;
    localparam int KIND_W  = 2;
    localparam int CFG_IW  = 2;

    localparam logic [COUNT_W-1:0] CNT_MAX =
        COUNT_W'((MAX_DIVISIONS < 256) ? MAX_DIVISIONS : 256);
    localparam logic [COUNT_W-1:0] MIN_SECTORS = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] MIN_STACKS  = COUNT_W'(2);

    localparam logic signed [XY_W-1:0]   CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [PROD_W-1:0] POS_LIM     = PROD_W'(65535);
    localparam logic signed [PROD_W-1:0] ROUND_HALF  = PROD_W'(64'd1 << 29);

    localparam logic [CFG_IW-1:0] CFG_RADIUS  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SECTORS = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_STACKS  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_VERTEX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd2;

    typedef enum logic [1:0] {
        PH_VERT = 2'd0,
        PH_TRI  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic restart;
        logic div_go;
        logic cor_go;
        logic mul_c;
        logic mul_s;
        logic wr_first;
        logic wr_second;
        logic row_mode;
        logic tri_go;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic phase_vert;
        logic tri_ok;
        logic need_row;
        logic div_done;
        logic cor_done;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/uv_sphere_mesh_generator.sv =====
// UV sphere mesh generator: one mesh element per input item.
// Input channel (i_valid / o_stall): i_restart=1 starts a new mesh and returns
// vertex 0; i_restart=0 returns the next element. Vertices come first, row by
// row, then the triangles of each cell; the final triangle has o_last set.
// Further items after the end return kind "finished" with all fields zero.
// Output channel (o_valid / i_stall): one result per item, held in registers
// until taken; the next item is accepted only after the result is taken.
// Config port (i_cfg_valid / o_cfg_ready, always ready): index 0 radius,
// 1 sector count, 2 stack count; write only while no item is in progress.
// Steps from acceptance to o_valid: a triangle or finished item goes from
// dispatch straight to the result registers; a vertex passes dispatch, the
// angle divider, the CORDIC and the scaling multiplier. A restart, and the
// last vertex of each row but the final one, add a second such pass for a
// row's ring radius and height.
// Synchronous active-low reset: radius 1.0, 36 sectors, 18 stacks, mesh in
// the finished state, no result pending. A stalled result holds its value.
`default_nettype none
module uv_sphere_mesh_generator
    import uvs_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire                      i_restart,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic [KIND_W-1:0]        o_kind,
    output logic signed [POS_W-1:0]  o_pos_x,
    output logic signed [POS_W-1:0]  o_pos_y,
    output logic signed [POS_W-1:0]  o_pos_z,
    output logic [IDX_W-1:0]         o_index_a,
    output logic [IDX_W-1:0]         o_index_b,
    output logic [IDX_W-1:0]         o_index_c,
    output logic                     o_last,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [CFG_IW-1:0]         i_cfg_index,
    input  wire [RAD_W-1:0]          i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    assign o_cfg_ready = 1'b1;

    uvs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_restart (i_restart),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    uvs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_kind      (o_kind),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_index_a   (o_index_a),
        .o_index_b   (o_index_b),
        .o_index_c   (o_index_c),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

// ===== rtl/uvs_ctrl.sv =====
`default_nettype none
module uvs_ctrl
    import uvs_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_valid,
    input  wire     i_restart,
    output logic    o_stall,
    output logic    o_valid,
    input  wire     i_stall,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_DIVGO = 9'b000000100,
        S_DIVW  = 9'b000001000,
        S_CORW  = 9'b000010000,
        S_M1    = 9'b000100000,
        S_M2    = 9'b001000000,
        S_M3    = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_restart, n_restart;
    logic   r_mode, n_mode;         // 1: row load, 0: vertex
    logic   r_then_vtx, n_then_vtx; // row load followed by a vertex

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state    = r_state;
        n_restart  = r_restart;
        n_mode     = r_mode;
        n_then_vtx = r_then_vtx;
        o_cmd      = '0;
        o_cmd.row_mode = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_restart = i_restart;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                priority if (r_restart) begin
                    o_cmd.restart = 1'b1;
                    n_mode     = 1'b1;
                    n_then_vtx = 1'b1;
                    n_state    = S_DIVGO;
                end else if (i_st.phase_vert) begin
                    n_mode  = 1'b0;
                    n_state = S_DIVGO;
                end else if (i_st.tri_ok) begin
                    o_cmd.tri_go = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_DIVGO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIVW;
            end
            S_DIVW: begin
                if (i_st.div_done) begin
                    o_cmd.cor_go = 1'b1;
                    n_state      = S_CORW;
                end
            end
            S_CORW: begin
                if (i_st.cor_done) n_state = S_M1;
            end
            S_M1: begin
                o_cmd.mul_c = 1'b1;
                n_state     = S_M2;
            end
            S_M2: begin
                o_cmd.mul_s    = 1'b1;
                o_cmd.wr_first = 1'b1;
                n_state        = S_M3;
            end
            S_M3: begin
                o_cmd.wr_second = 1'b1;
                if (r_mode) begin
                    if (r_then_vtx) begin
                        n_mode     = 1'b0;
                        n_then_vtx = 1'b0;
                        n_state    = S_DIVGO;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (i_st.need_row) begin
                    n_mode     = 1'b1;
                    n_then_vtx = 1'b0;
                    n_state    = S_DIVGO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_restart  <= 1'b0;
            r_mode     <= 1'b0;
            r_then_vtx <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_restart  <= n_restart;
            r_mode     <= n_mode;
            r_then_vtx <= n_then_vtx;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/uvs_datapath.sv =====
`default_nettype none
module uvs_datapath
    import uvs_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [CFG_IW-1:0]         i_cfg_index,
    input  wire [RAD_W-1:0]          i_cfg_data,
    input  t_cmd                     i_cmd,
    output t_status                  o_st,
    output logic [KIND_W-1:0]        o_kind,
    output logic signed [POS_W-1:0]  o_pos_x,
    output logic signed [POS_W-1:0]  o_pos_y,
    output logic signed [POS_W-1:0]  o_pos_z,
    output logic [IDX_W-1:0]         o_index_a,
    output logic [IDX_W-1:0]         o_index_b,
    output logic [IDX_W-1:0]         o_index_c,
    output logic                     o_last
);

    function automatic logic [31:0] f_atan(input logic [4:0] i);
        unique case (i)
            5'd0:  f_atan = 32'h20000000;  5'd1:  f_atan = 32'h12E4051D;
            5'd2:  f_atan = 32'h09FB385B;  5'd3:  f_atan = 32'h051111D4;
            5'd4:  f_atan = 32'h028B0D43;  5'd5:  f_atan = 32'h0145D7E1;
            5'd6:  f_atan = 32'h00A2F61E;  5'd7:  f_atan = 32'h00517C55;
            5'd8:  f_atan = 32'h0028BE53;  5'd9:  f_atan = 32'h00145F2E;
            5'd10: f_atan = 32'h000A2F98;  5'd11: f_atan = 32'h000517CC;
            5'd12: f_atan = 32'h00028BE6;  5'd13: f_atan = 32'h000145F3;
            5'd14: f_atan = 32'h0000A2F9;  5'd15: f_atan = 32'h0000517C;
            5'd16: f_atan = 32'h000028BE;  5'd17: f_atan = 32'h0000145F;
            5'd18: f_atan = 32'h00000A2F;  5'd19: f_atan = 32'h00000517;
            5'd20: f_atan = 32'h0000028B;  5'd21: f_atan = 32'h00000145;
            5'd22: f_atan = 32'h000000A2;  5'd23: f_atan = 32'h00000051;
            default: f_atan = 32'h0;
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] f_round_sat(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + ROUND_HALF) >>> 30;
        if (t > POS_LIM)       f_round_sat = POS_W'(POS_LIM);
        else if (t < -POS_LIM) f_round_sat = POS_W'(-POS_LIM);
        else                   f_round_sat = POS_W'(t);
    endfunction

    // configuration
    logic [RAD_W-1:0]   r_radius;
    logic [COUNT_W-1:0] r_sec_cfg, r_stk_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RAD_W'(256);
            r_sec_cfg <= COUNT_W'(36);
            r_stk_cfg <= COUNT_W'(18);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIUS:  r_radius  <= i_cfg_data;
                CFG_SECTORS: r_sec_cfg <= i_cfg_data[COUNT_W-1:0];
                CFG_STACKS:  r_stk_cfg <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COUNT_W-1:0] sec, stk;
    always_comb begin
        sec = r_sec_cfg;
        if (sec < MIN_SECTORS) sec = MIN_SECTORS;
        if (sec > CNT_MAX)     sec = CNT_MAX;
        stk = r_stk_cfg;
        if (stk < MIN_STACKS) stk = MIN_STACKS;
        if (stk > CNT_MAX)    stk = CNT_MAX;
    end

    // mesh walk state
    t_phase             r_phase;
    logic [COUNT_W-1:0] r_row, r_col;
    logic               r_second;
    logic signed [POS_W-1:0] r_ring, r_height;

    logic [COUNT_W:0] row_p1, col_p1, sec_p1;
    assign row_p1 = {1'b0, r_row} + 1'b1;
    assign col_p1 = {1'b0, r_col} + 1'b1;
    assign sec_p1 = {1'b0, sec} + 1'b1;

    assign o_st.phase_vert = (r_phase == PH_VERT);
    assign o_st.tri_ok     = (r_phase == PH_TRI) && (r_row < stk);
    assign o_st.need_row   = (col_p1 > {1'b0, sec}) && (row_p1 <= {1'b0, stk});

    // triangle indices
    logic [19:0] k1w, k2w;
    logic [IDX_W-1:0] k1, k2;
    assign k1w = 20'(r_row) * 20'(sec_p1) + 20'(r_col);
    assign k2w = k1w + 20'(sec_p1);
    assign k1  = k1w[IDX_W-1:0];
    assign k2  = k2w[IDX_W-1:0];

    // restoring divider: count << shift / divisions
    logic [NUM_W-1:0]   r_num;
    logic [COUNT_W-1:0] r_rem, r_den;
    logic [NUM_CW-1:0]  r_dcnt;
    logic               r_dbusy, r_ddone;
    logic [COUNT_W:0]   trial;
    logic               tbit;
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign tbit  = (trial >= {1'b0, r_den});
    assign o_st.div_done = r_ddone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_go) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == NUM_CW'(1)) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_num  <= i_cmd.row_mode ? (NUM_W'(r_row) << (ANGLE_BITS - 1))
                                     : (NUM_W'(r_col) << ANGLE_BITS);
            r_den  <= i_cmd.row_mode ? stk : sec;
            r_rem  <= '0;
            r_dcnt <= NUM_CW'(NUM_W);
        end else if (r_dbusy) begin
            r_rem  <= tbit ? COUNT_W'(trial - {1'b0, r_den}) : trial[COUNT_W-1:0];
            r_num  <= {r_num[NUM_W-2:0], tbit};
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    // CORDIC, one micro-rotation a cycle
    logic [ANGLE_BITS-1:0]   ang;
    logic [29:0]             zfrac;
    logic signed [XY_W-1:0]  r_x, r_y, r_z;
    logic [1:0]              r_quad;
    logic [ITER_W-1:0]       r_icnt;
    logic                    r_cbusy, r_cdone;
    logic signed [XY_W-1:0]  dx, dy, at;
    logic signed [XY_W-1:0]  cos_v, sin_v;

    assign ang = i_cmd.row_mode
               ? ((ANGLE_BITS'(1) << (ANGLE_BITS - 2)) - r_num[ANGLE_BITS-1:0])
               : r_num[ANGLE_BITS-1:0];
    assign zfrac = 30'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    assign dx = r_y >>> r_icnt;
    assign dy = r_x >>> r_icnt;
    assign at = signed'(XY_W'(f_atan(5'(r_icnt))));
    assign o_st.cor_done = r_cdone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0;
            r_cdone <= 1'b0;
        end else begin
            r_cdone <= 1'b0;
            if (i_cmd.cor_go) begin
                r_cbusy <= 1'b1;
            end else if (r_cbusy && r_icnt == ITER_W'(CORDIC_ITERATIONS - 1)) begin
                r_cbusy <= 1'b0;
                r_cdone <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_go) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= signed'(XY_W'(zfrac));
            r_quad <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
            r_icnt <= '0;
        end else if (r_cbusy) begin
            if (!r_z[XY_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_icnt <= r_icnt + 1'b1;
        end
    end

    always_comb begin
        unique case (r_quad)
            2'd0:    begin cos_v = r_x;  sin_v = r_y;  end
            2'd1:    begin cos_v = -r_y; sin_v = r_x;  end
            2'd2:    begin cos_v = -r_x; sin_v = -r_y; end
            default: begin cos_v = r_y;  sin_v = -r_x; end
        endcase
    end

    // scaling multiplier, cos then sin
    logic signed [POS_W-1:0]  mul_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [POS_W-1:0]  scaled;
    assign mul_v  = i_cmd.row_mode ? signed'({1'b0, r_radius}) : r_ring;
    assign scaled = f_round_sat(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_c)      r_prod <= PROD_W'(mul_v) * PROD_W'(cos_v);
        else if (i_cmd.mul_s) r_prod <= PROD_W'(mul_v) * PROD_W'(sin_v);
    end

    // walk state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DONE;
            r_row    <= '0;
            r_col    <= '0;
            r_second <= 1'b0;
            r_ring   <= '0;
            r_height <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_phase  <= PH_VERT;
                r_row    <= '0;
                r_col    <= '0;
                r_second <= 1'b0;
            end
            if (i_cmd.wr_first && i_cmd.row_mode)  r_ring   <= scaled;
            if (i_cmd.wr_second && i_cmd.row_mode) r_height <= scaled;
            if (i_cmd.wr_second && !i_cmd.row_mode) begin
                if (col_p1 > {1'b0, sec}) begin
                    r_col <= '0;
                    if (row_p1 > {1'b0, stk}) begin
                        r_phase  <= PH_TRI;
                        r_row    <= '0;
                        r_second <= 1'b1;
                    end else begin
                        r_row <= row_p1[COUNT_W-1:0];
                    end
                end else begin
                    r_col <= col_p1[COUNT_W-1:0];
                end
            end
            if (i_cmd.tri_go) begin
                if (!r_second && row_p1 < {1'b0, stk}) begin
                    r_second <= 1'b1;
                end else begin
                    r_second <= 1'b0;
                    if (col_p1 >= {1'b0, sec}) begin
                        r_col <= '0;
                        r_row <= row_p1[COUNT_W-1:0];
                        if (row_p1 >= {1'b0, stk}) r_phase <= PH_DONE;
                    end else begin
                        r_col <= col_p1[COUNT_W-1:0];
                        if (r_row >= stk) r_phase <= PH_DONE;
                    end
                end
            end
            if (i_cmd.fin) r_phase <= PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_first && !i_cmd.row_mode) o_pos_x <= scaled;
        if (i_cmd.wr_second && !i_cmd.row_mode) begin
            o_kind    <= KIND_VERTEX;
            o_pos_y   <= scaled;
            o_pos_z   <= r_height;
            o_index_a <= '0;
            o_index_b <= '0;
            o_index_c <= '0;
            o_last    <= 1'b0;
        end
        if (i_cmd.tri_go) begin
            o_kind    <= KIND_TRIANGLE;
            o_pos_x   <= '0;
            o_pos_y   <= '0;
            o_pos_z   <= '0;
            o_index_a <= k1 + 1'b1;
            o_index_b <= r_second ? k2 : k1;
            o_index_c <= r_second ? k2 + 1'b1 : k2;
            if (!r_second && row_p1 < {1'b0, stk})
                o_last <= 1'b0;
            else if (col_p1 >= {1'b0, sec})
                o_last <= (row_p1 >= {1'b0, stk});
            else
                o_last <= (r_row >= stk);
        end
        if (i_cmd.fin) begin
            o_kind    <= KIND_DONE;
            o_pos_x   <= '0;
            o_pos_y   <= '0;
            o_pos_z   <= '0;
            o_index_a <= '0;
            o_index_b <= '0;
            o_index_c <= '0;
            o_last    <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import uvs_pkg::*;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] x, y, z;
        logic [IDX_W-1:0]        a, b, c;
        logic                    last;
    } t_element;

    localparam logic [31:0] ATAN_TURNS [16] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C
    };

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, i_restart = 1'b0, i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = CFG_RADIUS;
    logic [RAD_W-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_last, o_cfg_ready;
    logic [KIND_W-1:0] o_kind;
    logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic [IDX_W-1:0] o_index_a, o_index_b, o_index_c;

    uv_sphere_mesh_generator i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mirror of the block's registers and mesh walk
    logic [15:0] radius_q = 16'd256;
    logic [8:0] sectors_q = 9'd36, stacks_q = 9'd18;
    int unsigned row_q = 0, col_q = 0;
    t_phase phase_q = PH_DONE;
    logic second_q = 1'b0;
    longint ring_q = 0, height_q = 0;

    bit pending_restart[$];
    t_element expected_elements[$];
    int unsigned n_items = 0, n_vert = 0, n_tri = 0, n_done = 0, n_errors = 0;
    int unsigned send_gap = 0, take_stall = 0;
    bit took = 0, calm = 0;

    function automatic void sincos(input logic [15:0] ang, output longint c,
                                   output longint s);
        logic [31:0] a;
        longint x, y, z, dx, dy;
        a = {ang, 16'h0};
        z = longint'({34'b0, a[29:0]});
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        case (a[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint scale_q88(input longint v, input longint f);
        longint r;
        r = (v * f + (longint'(1) <<< 29)) >>> 30;
        if (r > 65535) r = 65535;
        if (r < -65535) r = -65535;
        return r;
    endfunction

    function automatic int unsigned eff_count(input logic [8:0] v, input int unsigned lo);
        if (v < lo) return lo;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic void load_row(input int unsigned stk);
        longint c, s;
        logic [15:0] ang;
        ang = 16'(16384 - ((longint'(row_q) << 15) / stk));
        sincos(ang, c, s);
        ring_q = scale_q88(radius_q, c);
        height_q = scale_q88(radius_q, s);
    endfunction

    function automatic t_element next_element(input bit restart);
        t_element e;
        int unsigned sec, stk;
        longint c, s, k1, k2;
        sec = eff_count(sectors_q, 3);
        stk = eff_count(stacks_q, 2);
        e = '{KIND_DONE, 0, 0, 0, 0, 0, 0, 0};
        if (restart) begin
            phase_q = PH_VERT; row_q = 0; col_q = 0; second_q = 0;
            load_row(stk);
        end
        if (phase_q == PH_VERT) begin
            sincos(16'((longint'(col_q) << 16) / sec), c, s);
            e.kind = KIND_VERTEX;
            e.x = POS_W'(scale_q88(ring_q, c));
            e.y = POS_W'(scale_q88(ring_q, s));
            e.z = POS_W'(height_q);
            col_q++;
            if (col_q > sec) begin
                col_q = 0;
                row_q++;
                if (row_q > stk) begin
                    phase_q = PH_TRI; row_q = 0; second_q = 1;
                end else begin
                    load_row(stk);
                end
            end
        end else if (phase_q == PH_TRI && row_q < stk) begin
            k1 = longint'(row_q) * (sec + 1) + col_q;
            k2 = k1 + sec + 1;
            e.kind = KIND_TRIANGLE;
            e.a = IDX_W'(k1 + 1);
            e.b = second_q ? IDX_W'(k2) : IDX_W'(k1);
            e.c = second_q ? IDX_W'(k2 + 1) : IDX_W'(k2);
            if (!second_q && row_q + 1 < stk) begin
                second_q = 1;
            end else begin
                second_q = 0;
                col_q++;
                if (col_q >= sec) begin
                    col_q = 0;
                    row_q++;
                end
                if (row_q >= stk) begin
                    phase_q = PH_DONE;
                    e.last = 1'b1;
                end
            end
        end else begin
            phase_q = PH_DONE;
        end
        return e;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        n_errors++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // item acceptance, config writes and result checking
    always @(posedge i_clk) begin
        t_element e;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RADIUS:  radius_q <= i_cfg_data;
                CFG_SECTORS: sectors_q <= i_cfg_data[8:0];
                CFG_STACKS:  stacks_q <= i_cfg_data[8:0];
                default: ;
            endcase
        end
        if (i_valid && !o_stall) begin
            expected_elements.push_back(next_element(pending_restart.pop_front()));
            n_items++;
            took = 1;
        end
        if (o_valid && !i_stall) begin
            take_stall = calm ? 0 : $urandom_range(0, 4);
            if (expected_elements.size() == 0) begin
                n_errors++;
                $display("%0t: result with nothing expected", $time);
            end else begin
                e = expected_elements.pop_front();
                case (e.kind)
                    KIND_VERTEX:   n_vert++;
                    KIND_TRIANGLE: n_tri++;
                    default:       n_done++;
                endcase
                if (o_kind !== e.kind) report("kind", o_kind, e.kind);
                if (o_pos_x !== e.x) report("pos_x", o_pos_x, e.x);
                if (o_pos_y !== e.y) report("pos_y", o_pos_y, e.y);
                if (o_pos_z !== e.z) report("pos_z", o_pos_z, e.z);
                if (o_index_a !== e.a) report("index_a", o_index_a, e.a);
                if (o_index_b !== e.b) report("index_b", o_index_b, e.b);
                if (o_index_c !== e.c) report("index_c", o_index_c, e.c);
                if (o_last !== e.last) report("last", o_last, e.last);
            end
        end
    end

    // driver: one item at a time from the pending queue
    always @(negedge i_clk) begin
        logic v;
        v = i_valid;
        if (i_rst_n && (!i_valid || took)) begin
            if (took) send_gap = calm ? 0 : $urandom_range(0, 4);
            took = 0;
            v = 0;
            if (send_gap > 0) send_gap--;
            else if (pending_restart.size() > 0) begin
                v = 1;
                i_restart <= pending_restart[0];
            end
        end
        i_valid <= v;
        if (o_valid && take_stall > 0) begin
            i_stall <= 1'b1;
            take_stall--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic wait_idle();
        while (pending_restart.size() > 0 || expected_elements.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [RAD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one mesh run: optional restart, then steps with the odd stray restart
    task automatic mesh_run(input int rad, input int sec, input int stk,
                            input int steps, input bit restart);
        wait_idle();
        write_reg(CFG_RADIUS, RAD_W'(rad));
        write_reg(CFG_SECTORS, RAD_W'(sec));
        write_reg(CFG_STACKS, RAD_W'(stk));
        calm = ($urandom_range(0, 3) == 0);
        if (restart) pending_restart.push_back(1'b1);
        repeat (steps) pending_restart.push_back($urandom_range(0, 39) == 0);
    endtask

    initial begin
        int sec, stk, total;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // finished after reset, then a restart into the default mesh
        pending_restart.push_back(1'b0);
        pending_restart.push_back(1'b1);
        repeat (4) pending_restart.push_back(1'b0);
        // smallest mesh, all the way through and past the end
        mesh_run(256, 3, 2, 20, 1);
        mesh_run(65535, 3, 2, 20, 1);
        mesh_run(0, 4, 3, 8, 1);
        mesh_run(65535, 256, 2, 12, 1);
        mesh_run(40000, 3, 256, 30, 1);
        mesh_run($urandom_range(0, 65535), 0, 511, 12, 1);
        mesh_run($urandom_range(0, 65535), 511, 0, 10, 1);
        // counts shrunk mid-mesh
        mesh_run(1000, 6, 4, 10, 1);
        mesh_run(1000, 3, 2, 40, 0);

        while (n_items + pending_restart.size() < 550) begin
            sec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 8);
            stk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 5);
            total = (eff_count(9'(sec), 3) + 1) * (eff_count(9'(stk), 2) + 1)
                    + 2 * eff_count(9'(sec), 3) * (eff_count(9'(stk), 2) - 1);
            if (total > 120) total = $urandom_range(10, 60);
            else total += $urandom_range(0, 3);
            mesh_run($urandom_range(0, 9) == 0 ? 65535 : $urandom_range(0, 65535),
                     sec, stk, total, $urandom_range(0, 4) != 0);
        end
        wait_idle();

        $display("Run covered %0d items: %0d vertices, %0d triangles, %0d finished steps.",
                 n_items, n_vert, n_tri, n_done);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", expected_elements.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
